>>> src/assert_macros.svh
// Assertion macros shared by the keyboard translator RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SKBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SKBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/skbd_pkg.sv
// Shared types, constants and translation tables for the keyboard translator.
// No dependencies.
package skbd_pkg;

  localparam int unsigned NumCodes = 128;
  localparam int unsigned CodeW    = $clog2(NumCodes);
  localparam int unsigned CharW    = 7;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  localparam logic [7:0]       PauseCode = 8'hE1;
  localparam logic [CharW-1:0] CaseDist  = 7'd32;
  localparam logic [CharW-1:0] UpperA    = 7'd65;
  localparam logic [CharW-1:0] UpperZ    = 7'd90;
  localparam logic [CharW-1:0] LowerA    = 7'd97;
  localparam logic [CharW-1:0] LowerZ    = 7'd122;

  localparam logic [CodeW-1:0] CapsCodeRst   = 7'd58;
  localparam logic [CodeW-1:0] LshiftCodeRst = 7'd42;
  localparam logic [CodeW-1:0] RshiftCodeRst = 7'd54;

  typedef enum logic [1:0] {
    RegCapsCode   = 2'd0,
    RegLshiftCode = 2'd1,
    RegRshiftCode = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CodeW-1:0] caps_code;
    logic [CodeW-1:0] lshift_code;
    logic [CodeW-1:0] rshift_code;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] scan_code;
    logic       press;
  } item_t;

  typedef struct packed {
    logic [CharW-1:0] event_char;
    logic [CharW-1:0] last_char;
    logic [CodeW-1:0] last_code;
    logic [CodeW-1:0] prior_code;
    logic             key_now_down;
    logic             caps_on;
    logic             pause_seen;
  } rslt_t;

  // Keypad and other codes shared by both tables.
  function automatic logic [CharW-1:0] common_char(input logic [CodeW-1:0] code);
    logic [CharW-1:0] ch;
    ch = '0;
    case (code)
      7'd1:  ch = 7'd27;
      7'd14: ch = 7'd8;
      7'd15: ch = 7'd9;
      7'd28: ch = 7'd13;
      7'd55: ch = 7'd42;
      7'd57: ch = 7'd32;
      7'd71: ch = 7'd55;
      7'd72: ch = 7'd56;
      7'd73: ch = 7'd57;
      7'd74: ch = 7'd45;
      7'd75: ch = 7'd52;
      7'd76: ch = 7'd53;
      7'd77: ch = 7'd54;
      7'd78: ch = 7'd43;
      7'd79: ch = 7'd49;
      7'd80: ch = 7'd50;
      7'd81: ch = 7'd51;
      7'd82: ch = 7'd48;
      7'd83: ch = 7'd127;
      default: ch = '0;
    endcase
    return ch;
  endfunction

  function automatic logic [CharW-1:0] plain_char(input logic [CodeW-1:0] code);
    logic [CharW-1:0] ch;
    ch = common_char(code);
    case (code)
      7'd2:  ch = 7'd49;
      7'd3:  ch = 7'd50;
      7'd4:  ch = 7'd51;
      7'd5:  ch = 7'd52;
      7'd6:  ch = 7'd53;
      7'd7:  ch = 7'd54;
      7'd8:  ch = 7'd55;
      7'd9:  ch = 7'd56;
      7'd10: ch = 7'd57;
      7'd11: ch = 7'd48;
      7'd12: ch = 7'd45;
      7'd13: ch = 7'd61;
      7'd16: ch = 7'd113;
      7'd17: ch = 7'd119;
      7'd18: ch = 7'd101;
      7'd19: ch = 7'd114;
      7'd20: ch = 7'd116;
      7'd21: ch = 7'd121;
      7'd22: ch = 7'd117;
      7'd23: ch = 7'd105;
      7'd24: ch = 7'd111;
      7'd25: ch = 7'd112;
      7'd26: ch = 7'd91;
      7'd27: ch = 7'd93;
      7'd30: ch = 7'd97;
      7'd31: ch = 7'd115;
      7'd32: ch = 7'd100;
      7'd33: ch = 7'd102;
      7'd34: ch = 7'd103;
      7'd35: ch = 7'd104;
      7'd36: ch = 7'd106;
      7'd37: ch = 7'd107;
      7'd38: ch = 7'd108;
      7'd39: ch = 7'd59;
      7'd40: ch = 7'd39;
      7'd41: ch = 7'd96;
      7'd43: ch = 7'd92;
      7'd44: ch = 7'd122;
      7'd45: ch = 7'd120;
      7'd46: ch = 7'd99;
      7'd47: ch = 7'd118;
      7'd48: ch = 7'd98;
      7'd49: ch = 7'd110;
      7'd50: ch = 7'd109;
      7'd51: ch = 7'd44;
      7'd52: ch = 7'd46;
      7'd53: ch = 7'd47;
      default: ;
    endcase
    return ch;
  endfunction

  function automatic logic [CharW-1:0] shift_char(input logic [CodeW-1:0] code);
    logic [CharW-1:0] ch;
    ch = common_char(code);
    case (code)
      7'd2:  ch = 7'd33;
      7'd3:  ch = 7'd64;
      7'd4:  ch = 7'd35;
      7'd5:  ch = 7'd36;
      7'd6:  ch = 7'd37;
      7'd7:  ch = 7'd94;
      7'd8:  ch = 7'd38;
      7'd9:  ch = 7'd42;
      7'd10: ch = 7'd40;
      7'd11: ch = 7'd41;
      7'd12: ch = 7'd95;
      7'd13: ch = 7'd43;
      7'd16: ch = 7'd81;
      7'd17: ch = 7'd87;
      7'd18: ch = 7'd69;
      7'd19: ch = 7'd82;
      7'd20: ch = 7'd84;
      7'd21: ch = 7'd89;
      7'd22: ch = 7'd85;
      7'd23: ch = 7'd73;
      7'd24: ch = 7'd79;
      7'd25: ch = 7'd80;
      7'd26: ch = 7'd123;
      7'd27: ch = 7'd125;
      7'd30: ch = 7'd65;
      7'd31: ch = 7'd83;
      7'd32: ch = 7'd68;
      7'd33: ch = 7'd70;
      7'd34: ch = 7'd71;
      7'd35: ch = 7'd72;
      7'd36: ch = 7'd74;
      7'd37: ch = 7'd75;
      7'd38: ch = 7'd76;
      7'd39: ch = 7'd58;
      7'd40: ch = 7'd34;
      7'd41: ch = 7'd126;
      7'd43: ch = 7'd124;
      7'd44: ch = 7'd90;
      7'd45: ch = 7'd88;
      7'd46: ch = 7'd67;
      7'd47: ch = 7'd86;
      7'd48: ch = 7'd66;
      7'd49: ch = 7'd78;
      7'd50: ch = 7'd77;
      7'd51: ch = 7'd60;
      7'd52: ch = 7'd62;
      7'd53: ch = 7'd63;
      default: ;
    endcase
    return ch;
  endfunction

endpackage

>>> src/skbd_cfg.sv
// APB-style register file for the caps lock and shift key codes.
// Depends on skbd_pkg.
module skbd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [skbd_pkg::AddrW-1:0]  paddr,
  input  logic [skbd_pkg::DataW-1:0]  pwdata,
  output logic [skbd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output skbd_pkg::cfg_t              cfg_o
);

  skbd_pkg::cfg_t     cfg_q;
  skbd_pkg::cfg_reg_e reg_sel;
  logic               wr_en;
  logic [skbd_pkg::CodeW-1:0] rd_val;

  assign reg_sel = skbd_pkg::cfg_reg_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.caps_code   <= skbd_pkg::CapsCodeRst;
      cfg_q.lshift_code <= skbd_pkg::LshiftCodeRst;
      cfg_q.rshift_code <= skbd_pkg::RshiftCodeRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        skbd_pkg::RegCapsCode:   cfg_q.caps_code   <= pwdata[skbd_pkg::CodeW-1:0];
        skbd_pkg::RegLshiftCode: cfg_q.lshift_code <= pwdata[skbd_pkg::CodeW-1:0];
        skbd_pkg::RegRshiftCode: cfg_q.rshift_code <= pwdata[skbd_pkg::CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      skbd_pkg::RegCapsCode:   rd_val = cfg_q.caps_code;
      skbd_pkg::RegLshiftCode: rd_val = cfg_q.lshift_code;
      skbd_pkg::RegRshiftCode: rd_val = cfg_q.rshift_code;
      default:                 rd_val = '0;
    endcase
  end

  assign prdata = {{(skbd_pkg::DataW-skbd_pkg::CodeW){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

endmodule

>>> src/skbd_xlate.sv
// Key map, caps/pause state and scan code translation; state commits on adv_i.
// Depends on skbd_pkg.
module skbd_xlate (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  skbd_pkg::item_t       item_i,
  input  skbd_pkg::cfg_t        cfg_i,
  output skbd_pkg::rslt_t       res_o
);

  logic [skbd_pkg::NumCodes-1:0] key_map_q, key_map_d;
  logic                          caps_q, caps_d;
  logic                          pause_q, pause_d;
  logic [skbd_pkg::CodeW-1:0]    cur_q, cur_d;
  logic [skbd_pkg::CodeW-1:0]    prev_q, prev_d;
  logic [skbd_pkg::CodeW-1:0]    scan_q, scan_d;
  logic [skbd_pkg::CharW-1:0]    char_q, char_d;

  logic [skbd_pkg::CodeW-1:0]    idx;
  logic                          shift_dn;
  logic [skbd_pkg::CharW-1:0]    tab_ch;
  logic [skbd_pkg::CharW-1:0]    ch;
  logic                          down;

  assign idx = item_i.scan_code[skbd_pkg::CodeW-1:0];

  always_comb begin
    key_map_d = key_map_q;
    caps_d    = caps_q;
    pause_d   = pause_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    scan_d    = scan_q;
    char_d    = char_q;
    ch        = '0;
    down      = 1'b0;
    shift_dn  = 1'b0;
    tab_ch    = '0;
    if (item_i.cmd) begin
      key_map_d = '0;
      scan_d    = '0;
      char_d    = '0;
    end else if (item_i.scan_code == skbd_pkg::PauseCode) begin
      pause_d = 1'b1;
    end else if (!item_i.scan_code[7]) begin
      if (!item_i.press) begin
        key_map_d[idx] = 1'b0;
      end else begin
        prev_d         = cur_q;
        cur_d          = idx;
        scan_d         = idx;
        key_map_d[idx] = 1'b1;
        if (idx == cfg_i.caps_code) begin
          caps_d = ~caps_q;
        end
        // the pressed key itself counts as held
        shift_dn = key_map_q[cfg_i.lshift_code] | (idx == cfg_i.lshift_code) |
                   key_map_q[cfg_i.rshift_code] | (idx == cfg_i.rshift_code);
        if (shift_dn) begin
          tab_ch = skbd_pkg::shift_char(idx);
          ch     = tab_ch;
          if (caps_d && tab_ch >= skbd_pkg::UpperA && tab_ch <= skbd_pkg::UpperZ) begin
            ch = tab_ch + skbd_pkg::CaseDist;
          end
        end else begin
          tab_ch = skbd_pkg::plain_char(idx);
          ch     = tab_ch;
          if (caps_d && tab_ch >= skbd_pkg::LowerA && tab_ch <= skbd_pkg::LowerZ) begin
            ch = tab_ch - skbd_pkg::CaseDist;
          end
        end
        if (ch != '0) begin
          char_d = ch;
        end
      end
      down = item_i.press;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_map_q <= '0;
      caps_q    <= 1'b0;
      pause_q   <= 1'b0;
      cur_q     <= '0;
      prev_q    <= '0;
      scan_q    <= '0;
      char_q    <= '0;
    end else if (adv_i) begin
      key_map_q <= key_map_d;
      caps_q    <= caps_d;
      pause_q   <= pause_d;
      cur_q     <= cur_d;
      prev_q    <= prev_d;
      scan_q    <= scan_d;
      char_q    <= char_d;
    end
  end

  assign res_o.event_char   = ch;
  assign res_o.last_char    = char_d;
  assign res_o.last_code    = scan_d;
  assign res_o.prior_code   = prev_d;
  assign res_o.key_now_down = down;
  assign res_o.caps_on      = caps_d;
  assign res_o.pause_seen   = pause_d;

endmodule

>>> src/scancode_to_ascii_keyboard_top.sv
// Top level of the scan code to ASCII keyboard translator.
// Depends on skbd_pkg, skbd_cfg, skbd_xlate and assert_macros.svh.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------
//   in       | in_valid_i / in_ready_o   | cmd_i, scan_code_i, press_i
//   out      | out_valid_o / out_ready_i | event_char_o .. pause_seen_o
//   config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One request per cycle sustained while out_ready_i stays high; a result
// is valid once its request has passed the input register and then the
// result register, which is loaded from the table lookup and key map update.
// Reset clears the key map, caps and pause flags and loads default key codes.
// A stalled result holds in the output register; the input register keeps
// taking requests until both registers are full.
`include "assert_macros.svh"

module scancode_to_ascii_keyboard_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [7:0]                          scan_code_i,
  input  logic                                press_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [skbd_pkg::CharW-1:0]          event_char_o,
  output logic [skbd_pkg::CharW-1:0]          last_char_o,
  output logic [skbd_pkg::CodeW-1:0]          last_code_o,
  output logic [skbd_pkg::CodeW-1:0]          prior_code_o,
  output logic                                key_now_down_o,
  output logic                                caps_on_o,
  output logic                                pause_seen_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [skbd_pkg::AddrW-1:0]          paddr,
  input  logic [skbd_pkg::DataW-1:0]          pwdata,
  output logic [skbd_pkg::DataW-1:0]          prdata,
  output logic                                pready
);

  skbd_pkg::cfg_t  cfg;
  skbd_pkg::item_t in_item;
  skbd_pkg::item_t s1_item_q;
  skbd_pkg::rslt_t res;
  skbd_pkg::rslt_t out_q;
  logic            s1_valid_q;
  logic            out_valid_q;
  logic            adv;

  assign in_item.cmd       = cmd_i;
  assign in_item.scan_code = scan_code_i;
  assign in_item.press     = press_i;

  assign adv        = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | adv;

  skbd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  skbd_xlate u_xlate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_char_o   = out_q.event_char;
  assign last_char_o    = out_q.last_char;
  assign last_code_o    = out_q.last_code;
  assign prior_code_o   = out_q.prior_code;
  assign key_now_down_o = out_q.key_now_down;
  assign caps_on_o      = out_q.caps_on;
  assign pause_seen_o   = out_q.pause_seen;

  `SKBD_ASSERT(a_clear_zeroes_last, (adv && s1_item_q.cmd) |=> (last_char_o == '0 && last_code_o == '0), "clear did not zero last codes")
  `SKBD_ASSERT(a_char_tracks_last, (out_valid_o && event_char_o != '0) |-> (last_char_o == event_char_o), "last char differs from event char")
  `SKBD_ASSERT(a_pause_sticky, (out_valid_o && pause_seen_o) |=> (!out_valid_o || pause_seen_o), "pause flag dropped")
  `SKBD_ASSERT_ALWAYS(a_ready_when_empty, (rst_ni && !out_valid_o) |-> in_ready_o, "input stalled with empty output")

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for scancode_to_ascii_keyboard_top: key events and clear requests
// in, one translated result per request out, key codes set over APB between phases.
// Depends on skbd_pkg for widths, register names and the request and result structs.
module tb;
  import skbd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldOff    = 80;

  localparam bit [CharW-1:0] BaseGlyph [NumCodes] = '{
    0, 27, 49, 50, 51, 52, 53, 54, 55, 56, 57, 48, 45, 61, 8, 9,
    113, 119, 101, 114, 116, 121, 117, 105, 111, 112, 91, 93, 13, 0, 97, 115,
    100, 102, 103, 104, 106, 107, 108, 59, 39, 96, 0, 92, 122, 120, 99, 118,
    98, 110, 109, 44, 46, 47, 0, 42, 0, 32, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 55, 56, 57, 45, 52, 53, 54, 43, 49,
    50, 51, 48, 127, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  localparam bit [CharW-1:0] ShiftGlyph [NumCodes] = '{
    0, 27, 33, 64, 35, 36, 37, 94, 38, 42, 40, 41, 95, 43, 8, 9,
    81, 87, 69, 82, 84, 89, 85, 73, 79, 80, 123, 125, 13, 0, 65, 83,
    68, 70, 71, 72, 74, 75, 76, 58, 34, 126, 0, 124, 90, 88, 67, 86,
    66, 78, 77, 60, 62, 63, 0, 42, 0, 32, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 55, 56, 57, 45, 52, 53, 54, 43, 49,
    50, 51, 48, 127, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  class keystroke_tracker;
    bit             down_map [NumCodes];
    bit             held_map [NumCodes];
    bit             caps;
    bit             paused;
    bit [CodeW-1:0] cur_make;
    bit [CodeW-1:0] prev_make;
    bit [CodeW-1:0] last_scan;
    bit [CharW-1:0] last_ch;
    bit [CodeW-1:0] caps_key   = CapsCodeRst;
    bit [CodeW-1:0] lshift_key = LshiftCodeRst;
    bit [CodeW-1:0] rshift_key = RshiftCodeRst;
    rslt_t          due [$];
    int unsigned    errors;

    function void set_code(cfg_reg_e which, bit [CodeW-1:0] value);
      case (which)
        RegCapsCode:   caps_key = value;
        RegLshiftCode: lshift_key = value;
        RegRshiftCode: rshift_key = value;
        default: ;
      endcase
    endfunction

    function bit [CodeW-1:0] code_of(cfg_reg_e which);
      case (which)
        RegCapsCode:   return caps_key;
        RegLshiftCode: return lshift_key;
        RegRshiftCode: return rshift_key;
        default:       return '0;
      endcase
    endfunction

    function void take_keystroke(item_t req);
      rslt_t          r;
      bit [CharW-1:0] ch;
      bit [CodeW-1:0] k;
      ch = '0;
      r.key_now_down = 1'b0;
      k = req.scan_code[CodeW-1:0];
      if (req.cmd) begin
        foreach (down_map[i]) down_map[i] = 1'b0;
        last_scan = '0;
        last_ch = '0;
      end else if (req.scan_code == PauseCode) begin
        paused = 1'b1;
      end else if (!req.scan_code[7]) begin
        if (!req.press) begin
          down_map[k] = 1'b0;
          held_map[k] = 1'b0;
        end else begin
          prev_make = cur_make;
          cur_make = k;
          last_scan = k;
          down_map[k] = 1'b1;
          held_map[k] = 1'b1;
          if (k == caps_key) caps = !caps;
          if (down_map[lshift_key] || down_map[rshift_key]) begin
            ch = ShiftGlyph[k];
            if (caps && ch >= UpperA && ch <= UpperZ) ch = ch + CaseDist;
          end else begin
            ch = BaseGlyph[k];
            if (caps && ch >= LowerA && ch <= LowerZ) ch = ch - CaseDist;
          end
          if (ch != '0) last_ch = ch;
        end
        r.key_now_down = down_map[k];
      end
      r.event_char = ch;
      r.last_char  = last_ch;
      r.last_code  = last_scan;
      r.prior_code = prev_make;
      r.caps_on    = caps;
      r.pause_seen = paused;
      due.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(rslt_t got);
      rslt_t want;
      if (due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = due.pop_front();
      cmp_field("event_char", want.event_char, got.event_char);
      cmp_field("last_char", want.last_char, got.last_char);
      cmp_field("last_code", want.last_code, got.last_code);
      cmp_field("prior_code", want.prior_code, got.prior_code);
      cmp_field("key_now_down", want.key_now_down, got.key_now_down);
      cmp_field("caps_on", want.caps_on, got.caps_on);
      cmp_field("pause_seen", want.pause_seen, got.pause_seen);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               cmd_i;
  logic [7:0]         scan_code_i;
  logic               press_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [CharW-1:0]   event_char_o;
  logic [CharW-1:0]   last_char_o;
  logic [CodeW-1:0]   last_code_o;
  logic [CodeW-1:0]   prior_code_o;
  logic               key_now_down_o;
  logic               caps_on_o;
  logic               pause_seen_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;

  keystroke_tracker   kt = new;
  bit                 calm;
  int unsigned        stall_req;
  int unsigned        sent;
  int unsigned        cycles;

  scancode_to_ascii_keyboard_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .scan_code_i    (scan_code_i),
    .press_i        (press_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_char_o   (event_char_o),
    .last_char_o    (last_char_o),
    .last_code_o    (last_code_o),
    .prior_code_o   (prior_code_o),
    .key_now_down_o (key_now_down_o),
    .caps_on_o      (caps_on_o),
    .pause_seen_o   (pause_seen_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rslt_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.event_char   = event_char_o;
      got.last_char    = last_char_o;
      got.last_code    = last_code_o;
      got.prior_code   = prior_code_o;
      got.key_now_down = key_now_down_o;
      got.caps_on      = caps_on_o;
      got.pause_seen   = pause_seen_o;
      kt.match_result(got);
    end
  end

  // result sink; a hold-off request is counted down here
  initial begin : sink
    int unsigned hold_left;
    int unsigned seen_req;
    hold_left = 0;
    seen_req = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req != seen_req) begin
        hold_left = HoldOff;
        seen_req = stall_req;
      end
      if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = calm || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  task automatic send_key(logic cmd, logic [7:0] code, logic press);
    item_t req;
    while (!calm && $urandom_range(0, 99) < 20) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    cmd_i       = cmd;
    scan_code_i = code;
    press_i     = press;
    do @(posedge clk_i); while (!in_ready_o);
    req.cmd = cmd;
    req.scan_code = code;
    req.press = press;
    kt.take_keystroke(req);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (kt.due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_xfer(bit wr, cfg_reg_e r, logic [DataW-1:0] wdata,
                          output logic [DataW-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {r, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_reg(cfg_reg_e r);
    logic [DataW-1:0] rd;
    apb_xfer(1'b0, r, '0, rd);
    if (rd !== DataW'(kt.code_of(r))) begin
      $error("prdata %s: expected %0d, got %0d", r.name(), kt.code_of(r), rd);
      kt.errors++;
    end
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CodeW-1:0] value);
    logic [DataW-1:0] rd;
    apb_xfer(1'b1, r, DataW'(value), rd);
    kt.set_code(r, value);
    check_reg(r);
  endtask

  task automatic set_codes(logic [CodeW-1:0] caps, logic [CodeW-1:0] lsh,
                           logic [CodeW-1:0] rsh);
    write_reg(RegCapsCode, caps);
    write_reg(RegLshiftCode, lsh);
    write_reg(RegRshiftCode, rsh);
  endtask

  // shift, chosen at random, held around one to four make/break pairs
  task automatic type_word();
    logic [CodeW-1:0] shift_key;
    logic [7:0]       key;
    bit               shifted;
    int unsigned      n;
    shifted = 1'($urandom_range(0, 1));
    shift_key = $urandom_range(0, 1) ? kt.lshift_key : kt.rshift_key;
    n = $urandom_range(1, 4);
    if (shifted) send_key(1'b0, {1'b0, shift_key}, 1'b1);
    repeat (n) begin
      key = 8'($urandom_range(2, 57));
      send_key(1'b0, key, 1'b1);
      send_key(1'b0, key, 1'b0);
    end
    if (shifted && $urandom_range(0, 9) != 0) send_key(1'b0, {1'b0, shift_key}, 1'b0);
  endtask

  task automatic send_noise();
    int unsigned pick;
    int unsigned which;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      send_key(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else if (pick < 6) begin
      send_key(1'b0, PauseCode, 1'($urandom_range(0, 1)));
    end else if (pick < 14) begin
      send_key(1'b0, 8'($urandom_range(128, 255)), 1'($urandom_range(0, 1)));
    end else if (pick < 24) begin
      which = $urandom_range(0, 2);
      send_key(1'b0, {1'b0, kt.code_of(cfg_reg_e'(which))}, 1'($urandom_range(0, 1)));
    end else if (pick < 80) begin
      send_key(1'b0, 8'($urandom_range(0, 83)), $urandom_range(0, 9) < 6);
    end else begin
      send_key(1'b0, 8'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_traffic(int unsigned count);
    int unsigned stop;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(0, 99) < 25) type_word();
      else send_noise();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = 1'b0;
    scan_code_i = '0;
    press_i     = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_reg(RegCapsCode);
    check_reg(RegLshiftCode);
    check_reg(RegRshiftCode);

    send_key(1'b0, 8'h00, 1'b1);
    send_key(1'b0, 8'h1E, 1'b1);
    send_key(1'b0, {1'b0, CapsCodeRst}, 1'b1);
    send_key(1'b0, 8'h1E, 1'b1);
    send_key(1'b0, {1'b0, LshiftCodeRst}, 1'b1);
    send_key(1'b0, 8'h1E, 1'b1);
    send_key(1'b0, 8'h02, 1'b1);
    send_key(1'b0, {1'b0, LshiftCodeRst}, 1'b0);
    send_key(1'b0, {1'b0, RshiftCodeRst}, 1'b1);
    send_key(1'b0, 8'h10, 1'b1);
    send_key(1'b0, {1'b0, RshiftCodeRst}, 1'b0);
    send_key(1'b0, {1'b0, CapsCodeRst}, 1'b1);
    send_key(1'b0, 8'h7F, 1'b1);
    send_key(1'b0, 8'h7F, 1'b0);
    send_key(1'b0, 8'h53, 1'b1);
    send_key(1'b0, PauseCode, 1'b1);
    send_key(1'b0, PauseCode, 1'b0);
    send_key(1'b0, 8'h80, 1'b1);
    send_key(1'b0, 8'hFF, 1'b0);
    send_key(1'b1, 8'hFF, 1'b1);
    send_key(1'b1, 8'h00, 1'b0);
    send_key(1'b0, 8'h1E, 1'b0);
    send_key(1'b0, 8'h39, 1'b1);
    drain();

    set_codes(7'd0, 7'd127, 7'd0);
    stall_req++;
    random_traffic(150);
    drain();

    set_codes(7'd127, 7'd0, 7'd127);
    calm = 1'b1;
    random_traffic(100);
    calm = 1'b0;
    random_traffic(60);
    drain();

    set_codes(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)));
    random_traffic(150);
    drain();

    set_codes(CapsCodeRst, LshiftCodeRst, RshiftCodeRst);
    stall_req++;
    random_traffic(150);
    drain();

    if (kt.errors == 0 && kt.due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/skbd_pkg.sv
src/skbd_cfg.sv
src/skbd_xlate.sv
src/scancode_to_ascii_keyboard_top.sv
tb/sv/tb.sv
